/* hdl/mrtc_pkg.sv */
// Shared types and constants for the memory region table check block.
package mrtc_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned KIND_W = 8;
  localparam int unsigned SUM_W  = 21;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CMD_W  = 2;

  localparam logic [ADDR_W-1:0] MB_BOUNDARY    = 32'h0010_0000;
  localparam logic [SUM_W-1:0]  FIRST_MB_PAGES = SUM_W'(1024 >> 2);
  localparam logic [SUM_W-1:0]  SUM_MAX        = 21'h1F_FFFF;
  localparam logic [SUM_W-1:0]  LIMIT_RESET    = 21'd262144;

  localparam logic [KIND_W-1:0] KIND_EMPTY = 8'd0;
  localparam logic [KIND_W-1:0] KIND_AVAIL = 8'd1;
  localparam logic [KIND_W-1:0] KIND_RESV  = 8'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_CHECK   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_SKIPPED = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_REFUSED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Query token walking the cell chain
  typedef struct packed {
    logic              valid;
    logic              avail;
    logic              resv;
    logic              found;
    logic [ADDR_W-1:0] addr;
  } token_t;

  // Table entry write
  typedef struct packed {
    logic [ADDR_W-1:0] rgn_start;
    logic [ADDR_W-1:0] rgn_end;
    logic              high;
    logic [KIND_W-1:0] kind;
  } entry_t;

endpackage

/* hdl/mrtc_in_if.sv */
// Input command channel: valid/ready with the command payload.
interface mrtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] base;
  logic [63:0] length;
  logic [31:0] end_addr;
  logic [7:0]  region_type;

  modport source (output valid, output cmd, output base, output length, output end_addr,
                  output region_type, input ready);
  modport sink   (input valid, input cmd, input base, input length, input end_addr,
                  input region_type, output ready);
endinterface

/* hdl/mrtc_out_if.sv */
// Result channel: valid/ready with status, availability and page total.
interface mrtc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        available;
  logic [20:0] page_total;

  modport source (output valid, output status, output available, output page_total,
                  input ready);
  modport sink   (input valid, input status, input available, input page_total,
                  output ready);
endinterface

/* hdl/mrtc_cell.sv */
// One table slot: holds a region and tests the passing query token against it.
module mrtc_cell #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned PAGE_BITS     = 12,
  parameter int unsigned CELL_IDX      = 0,
  localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mrtc_pkg::token_t      tok_i,
  input  logic [IDX_W-1:0]      idx_i,
  output mrtc_pkg::token_t      tok_o,
  output logic [IDX_W-1:0]      idx_o,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_idx_i,
  input  mrtc_pkg::entry_t      wr_i
);

  localparam logic [mrtc_pkg::ADDR_W-1:0] FRAME_MASK =
    ~((mrtc_pkg::ADDR_W'(1) << PAGE_BITS) - mrtc_pkg::ADDR_W'(1));

  logic [mrtc_pkg::ADDR_W-1:0] start_q, end_q;
  logic                        high_q;
  logic [mrtc_pkg::KIND_W-1:0] kind_q;

  mrtc_pkg::token_t   tok_q, tok_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               win;
  logic               sel;

  assign sel = wr_en_i && (wr_idx_i == IDX_W'(CELL_IDX));

  assign win = !high_q && (end_q != '0) && (tok_i.addr >= start_q)
               && (tok_i.addr < (end_q & FRAME_MASK));

  always_comb begin
    tok_d = tok_i;
    idx_d = idx_i;
    tok_d.avail = tok_i.avail | (win && (kind_q == mrtc_pkg::KIND_AVAIL));
    tok_d.resv  = tok_i.resv  | (win && (kind_q == mrtc_pkg::KIND_RESV));
    if (!tok_i.found && (kind_q == mrtc_pkg::KIND_EMPTY)) begin
      tok_d.found = 1'b1;
      idx_d       = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= mrtc_pkg::KIND_EMPTY;
      tok_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (sel) begin
        kind_q <= wr_i.kind;
      end
      tok_q <= tok_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel) begin
      start_q <= wr_i.rgn_start;
      end_q   <= wr_i.rgn_end;
      high_q  <= wr_i.high;
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

/* hdl/mrtc_ctrl.sv */
// Command sequencer: handshakes, load math, page sum, table writes, result register.
module mrtc_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned PAGE_BITS     = 12,
  localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES),
  localparam int unsigned SLOT_W       = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mrtc_in_if.sink                      in_i,
  mrtc_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [mrtc_pkg::SUM_W-1:0]   cfg_wdata_i,
  output mrtc_pkg::token_t             tok_o,
  input  mrtc_pkg::token_t             tok_i,
  input  logic [IDX_W-1:0]             idx_i,
  output logic                         wr_en_o,
  output logic [IDX_W-1:0]             wr_idx_o,
  output mrtc_pkg::entry_t             wr_o
);

  localparam int unsigned AW    = mrtc_pkg::ADDR_W;
  localparam int unsigned SW    = mrtc_pkg::SUM_W;
  localparam int unsigned ACC_W = SW + 1;
  localparam int unsigned PG_W  = AW - PAGE_BITS;
  localparam logic [AW-1:0] FRAME_MASK = ~((AW'(1) << PAGE_BITS) - AW'(1));

  mrtc_pkg::state_e state_q, state_d;

  logic [1:0]  cmd_q;
  logic [63:0] base_q, len_q;
  logic [31:0] end_addr_q;
  logic [7:0]  type_q;
  logic [AW-1:0] last_q;
  logic          high_q;
  logic          usable_q, found_q;
  logic [IDX_W-1:0] fidx_q;

  logic [SLOT_W-1:0] slot_q;
  logic [SW-1:0]     page_sum_q, page_sum_d;
  logic [SW-1:0]     page_limit_q;

  logic       out_valid_q;
  logic [1:0] out_status_q;
  logic       out_avail_q;

  logic accept, launch, fin, out_free, in_rdy;
  logic load_ok, resv_ok, add_pages;
  logic [63:0]    last_c;
  logic [AW-1:0]  fs, fe, diff;
  logic [PG_W-1:0] pages;
  logic [ACC_W-1:0] sum_wide, tot_wide;
  mrtc_pkg::status_e status_c;

  assign out_free = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_rdy;
  assign in_i.ready = in_rdy;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrtc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_i.cmd == mrtc_pkg::CMD_LOAD) begin
            state_d = mrtc_pkg::ST_PREP;
          end else if (in_i.cmd == mrtc_pkg::CMD_NOP) begin
            state_d = mrtc_pkg::ST_FINISH;
          end else begin
            state_d = mrtc_pkg::ST_SCAN;
          end
        end
      end
      mrtc_pkg::ST_PREP: state_d = mrtc_pkg::ST_FINISH;
      mrtc_pkg::ST_SCAN: begin
        if (tok_i.valid) begin
          state_d = mrtc_pkg::ST_FINISH;
        end
      end
      mrtc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = mrtc_pkg::ST_IDLE;
        end
      end
      default: state_d = mrtc_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_rdy = 1'b0;
    launch = 1'b0;
    fin    = 1'b0;
    unique case (state_q)
      mrtc_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        launch = in_i.valid && ((in_i.cmd == mrtc_pkg::CMD_RESERVE)
                                || (in_i.cmd == mrtc_pkg::CMD_CHECK));
      end
      mrtc_pkg::ST_FINISH: fin = out_free;
      default: ;
    endcase
  end

  always_comb begin
    tok_o       = '0;
    tok_o.valid = launch;
    tok_o.addr  = in_i.base[AW-1:0];
  end

  // Load and reserve decisions
  assign last_c  = base_q + len_q - 64'd1;
  assign load_ok = (cmd_q == mrtc_pkg::CMD_LOAD) && (len_q != '0)
                   && (slot_q < SLOT_W'(TABLE_ENTRIES));
  assign resv_ok = (cmd_q == mrtc_pkg::CMD_RESERVE) && usable_q && found_q;

  always_comb begin
    priority if (cmd_q == mrtc_pkg::CMD_LOAD) begin
      status_c = load_ok ? mrtc_pkg::STAT_DONE : mrtc_pkg::STAT_SKIPPED;
    end else if (cmd_q == mrtc_pkg::CMD_RESERVE) begin
      if (!usable_q) begin
        status_c = mrtc_pkg::STAT_REFUSED;
      end else if (!found_q) begin
        status_c = mrtc_pkg::STAT_FULL;
      end else begin
        status_c = mrtc_pkg::STAT_DONE;
      end
    end else begin
      status_c = mrtc_pkg::STAT_DONE;
    end
  end

  assign wr_en_o = fin && (load_ok || resv_ok);
  always_comb begin
    if (cmd_q == mrtc_pkg::CMD_LOAD) begin
      wr_idx_o     = slot_q[IDX_W-1:0];
      wr_o.rgn_start = base_q[AW-1:0];
      wr_o.rgn_end   = last_q;
      wr_o.high      = high_q;
      wr_o.kind      = type_q;
    end else begin
      wr_idx_o     = fidx_q;
      wr_o.rgn_start = base_q[AW-1:0];
      wr_o.rgn_end   = end_addr_q;
      wr_o.high      = 1'b0;
      wr_o.kind      = mrtc_pkg::KIND_RESV;
    end
  end

  // Page sum, saturating
  assign fs        = base_q[AW-1:0] & FRAME_MASK;
  assign fe        = last_q & FRAME_MASK;
  assign diff      = fe - fs;
  assign pages     = diff[AW-1:PAGE_BITS];
  assign add_pages = fin && load_ok && (type_q == mrtc_pkg::KIND_AVAIL) && !high_q
                     && (fs >= mrtc_pkg::MB_BOUNDARY);
  assign sum_wide  = ACC_W'(page_sum_q) + ACC_W'(pages);

  always_comb begin
    page_sum_d = page_sum_q;
    if (add_pages) begin
      if (sum_wide >= ACC_W'(mrtc_pkg::SUM_MAX)) begin
        page_sum_d = mrtc_pkg::SUM_MAX;
      end else begin
        page_sum_d = sum_wide[SW-1:0];
      end
    end
  end

  assign tot_wide = ACC_W'(page_sum_q) + ACC_W'(mrtc_pkg::FIRST_MB_PAGES);

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.available  = out_avail_q;
  assign out_o.page_total = (tot_wide > ACC_W'(page_limit_q)) ? page_limit_q
                                                              : tot_wide[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mrtc_pkg::ST_IDLE;
      slot_q       <= '0;
      page_sum_q   <= '0;
      page_limit_q <= mrtc_pkg::LIMIT_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      page_sum_q <= page_sum_d;
      if (fin && load_ok) begin
        slot_q <= slot_q + SLOT_W'(1);
      end
      if (cfg_we_i) begin
        page_limit_q <= cfg_wdata_i;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= in_i.cmd;
      base_q     <= in_i.base;
      len_q      <= in_i.length;
      end_addr_q <= in_i.end_addr;
      type_q     <= in_i.region_type;
    end
    if (state_q == mrtc_pkg::ST_PREP) begin
      last_q <= last_c[AW-1:0];
      high_q <= (base_q[63:AW] != '0) || (last_c[63:AW] != '0);
    end
    if ((state_q == mrtc_pkg::ST_SCAN) && tok_i.valid) begin
      usable_q <= tok_i.avail && !tok_i.resv;
      found_q  <= tok_i.found;
      fidx_q   <= idx_i;
    end
    if (fin) begin
      out_status_q <= status_c;
      out_avail_q  <= (cmd_q == mrtc_pkg::CMD_CHECK) && usable_q;
    end
  end

endmodule

/* hdl/memory_region_table_check.sv */
// Top level: memory region table check, a chain of slot cells with a sequencer.
// Check and reserve send a query token down the chain of slot cells from transfer to result
// (the token walks one slot cell per cycle); load passes through a prep state first.
// Throughput: one command in flight; next transfer taken as soon as the result is
// registered, even while it still waits on the output.
// Reset: slot kinds, load slot and page sum clear; page limit returns to 262144.
module memory_region_table_check #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned PAGE_BITS     = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mrtc_in_if.sink                    in_i,
  mrtc_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic [mrtc_pkg::SUM_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  mrtc_pkg::token_t  tok [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]  idx [TABLE_ENTRIES+1];
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  mrtc_pkg::entry_t  wr;

  assign idx[0] = '0;

  mrtc_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PAGE_BITS     (PAGE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tok_o       (tok[0]),
    .tok_i       (tok[TABLE_ENTRIES]),
    .idx_i       (idx[TABLE_ENTRIES]),
    .wr_en_o     (wr_en),
    .wr_idx_o    (wr_idx),
    .wr_o        (wr)
  );

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    mrtc_cell #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PAGE_BITS     (PAGE_BITS),
      .CELL_IDX      (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[g]),
      .idx_i    (idx[g]),
      .tok_o    (tok[g+1]),
      .idx_o    (idx[g+1]),
      .wr_en_i  (wr_en),
      .wr_idx_i (wr_idx),
      .wr_i     (wr)
    );
  end

endmodule

/* verif/memory_region_table_check_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the memory region table check block.
module memory_region_table_check_tb;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned PG_BITS = 12;
  localparam int unsigned AW = mrtc_pkg::ADDR_W;
  localparam int unsigned SW = mrtc_pkg::SUM_W;
  localparam int unsigned KW = mrtc_pkg::KIND_W;
  localparam logic [AW-1:0] FRAME_MASK = ~((32'd1 << PG_BITS) - 32'd1);
  localparam logic [SW-1:0] LIMIT_MAX = 21'd1048576;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    mrtc_pkg::status_e status;
    logic              available;
    logic [SW-1:0]     page_total;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [SW-1:0] cfg_wdata_i;

  mrtc_in_if  cmd_if ();
  mrtc_out_if res_if ();

  memory_region_table_check #(
    .TABLE_ENTRIES(ENTRIES),
    .PAGE_BITS    (PG_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the region table
  logic [AW-1:0] tbl_start [ENTRIES];
  logic [AW-1:0] tbl_end   [ENTRIES];
  logic          tbl_high  [ENTRIES];
  logic [KW-1:0] tbl_kind  [ENTRIES];
  int unsigned   next_load;
  logic [SW-1:0] pg_sum;
  logic [SW-1:0] pg_limit;

  outcome_t pending_outcomes[$];

  int error_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int cmd_seen[4] = '{0, 0, 0, 0};
  int status_seen[4] = '{0, 0, 0, 0};
  int usable_seen = 0;
  int gap_max = 6;
  int stall_max = 6;
  int stall_left = 0;
  int hold_cycles = 0;

  function automatic logic in_window(int s, logic [KW-1:0] kind, logic [AW-1:0] a);
    if (tbl_kind[s] != kind || tbl_high[s] || tbl_end[s] == '0) return 1'b0;
    return (a >= tbl_start[s]) && (a < (tbl_end[s] & FRAME_MASK));
  endfunction

  function automatic logic addr_usable(logic [AW-1:0] a);
    logic ok;
    ok = 1'b0;
    for (int i = 0; i < ENTRIES; i++) if (in_window(i, mrtc_pkg::KIND_AVAIL, a)) ok = 1'b1;
    for (int i = 0; i < ENTRIES; i++) if (in_window(i, mrtc_pkg::KIND_RESV, a)) ok = 1'b0;
    return ok;
  endfunction

  function automatic outcome_t apply_command(mrtc_pkg::cmd_e c, logic [63:0] b,
                                             logic [63:0] len, logic [31:0] ea,
                                             logic [7:0] rt);
    outcome_t o;
    logic [63:0] last;
    logic [AW-1:0] s, e, pages;
    logic hi;
    logic [SW:0] tot;
    int slot;
    o.status = mrtc_pkg::STAT_DONE;
    o.available = 1'b0;
    case (c)
      mrtc_pkg::CMD_LOAD: begin
        if (len == '0 || next_load >= ENTRIES) begin
          o.status = mrtc_pkg::STAT_SKIPPED;
        end else begin
          last = b + len - 64'd1;
          s = b[31:0];
          e = last[31:0];
          hi = (b[63:32] != '0) || (last[63:32] != '0);
          tbl_start[next_load] = s;
          tbl_end[next_load] = e;
          tbl_high[next_load] = hi;
          tbl_kind[next_load] = rt;
          next_load++;
          if (!hi && rt == mrtc_pkg::KIND_AVAIL
              && (s & FRAME_MASK) >= mrtc_pkg::MB_BOUNDARY) begin
            pages = ((e & FRAME_MASK) - (s & FRAME_MASK)) >> PG_BITS;
            if (pages >= {11'b0, mrtc_pkg::SUM_MAX - pg_sum}) pg_sum = mrtc_pkg::SUM_MAX;
            else pg_sum = pg_sum + pages[SW-1:0];
          end
        end
      end
      mrtc_pkg::CMD_RESERVE: begin
        if (!addr_usable(b[31:0])) begin
          o.status = mrtc_pkg::STAT_REFUSED;
        end else begin
          slot = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && tbl_kind[i] == mrtc_pkg::KIND_EMPTY) slot = i;
          if (slot < 0) begin
            o.status = mrtc_pkg::STAT_FULL;
          end else begin
            tbl_start[slot] = b[31:0];
            tbl_end[slot] = ea;
            tbl_high[slot] = 1'b0;
            tbl_kind[slot] = mrtc_pkg::KIND_RESV;
          end
        end
      end
      mrtc_pkg::CMD_CHECK: o.available = addr_usable(b[31:0]);
      default: ;
    endcase
    tot = {1'b0, pg_sum} + {1'b0, mrtc_pkg::FIRST_MB_PAGES};
    if (tot > {1'b0, pg_limit}) tot = {1'b0, pg_limit};
    o.page_total = tot[SW-1:0];
    return o;
  endfunction

  // Addresses biased toward region edges
  function automatic logic [AW-1:0] pick_address();
    int s;
    logic [AW-1:0] a;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 32'hFFFF_FFFF;
          2: return mrtc_pkg::MB_BOUNDARY;
          default: return mrtc_pkg::MB_BOUNDARY - 32'd1;
        endcase
      end
      default: begin
        s = $urandom_range(0, ENTRIES - 1);
        if (tbl_kind[s] == mrtc_pkg::KIND_EMPTY) return $urandom;
        a = $urandom_range(0, 1) ? tbl_start[s] : (tbl_end[s] & FRAME_MASK);
        return a + 32'($urandom_range(0, 4)) - 32'd2;
      end
    endcase
  endfunction

  function automatic void report_field(string what, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      error_count++;
      if (error_count <= 50)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, expv, actv);
    end
  endfunction

  task automatic issue_command(mrtc_pkg::cmd_e c, logic [63:0] b, logic [63:0] len,
                               logic [31:0] ea, logic [7:0] rt);
    int gap;
    outcome_t o;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_if.cmd <= c;
    cmd_if.base <= b;
    cmd_if.length <= len;
    cmd_if.end_addr <= ea;
    cmd_if.region_type <= rt;
    cmd_if.valid <= 1'b1;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    o = apply_command(c, b, len, ea, rt);
    pending_outcomes.push_back(o);
    cmd_seen[int'(c)]++;
    status_seen[int'(o.status)]++;
    if (o.available) usable_seen++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_page_limit(logic [SW-1:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pg_limit = v;
  endtask

  task automatic random_command(int spare_slots);
    int pick;
    logic [63:0] b, len;
    logic [31:0] ea;
    logic [7:0] rt;
    pick = $urandom_range(0, 99);
    b = {$urandom, $urandom};
    len = {$urandom, $urandom};
    ea = $urandom;
    rt = 8'($urandom);
    if (pick < 8 && (spare_slots == 0 || next_load + spare_slots < ENTRIES)) begin
      if ($urandom_range(0, 7) != 0) b[63:32] = '0;
      case ($urandom_range(0, 15))
        0: len = '0;
        1: ;
        2: len = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 32'h3FFF));
        default: len = 64'($urandom_range(1, 32'h0FFF_FFFF));
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2, 3: rt = mrtc_pkg::KIND_AVAIL;
        4, 5: rt = mrtc_pkg::KIND_RESV;
        6: rt = mrtc_pkg::KIND_EMPTY;
        default: ;
      endcase
      issue_command(mrtc_pkg::CMD_LOAD, b, len, ea, rt);
    end else if (pick < 30) begin
      b[31:0] = pick_address();
      if ($urandom_range(0, 7) != 0) ea = b[31:0] + 32'($urandom_range(0, 32'h0010_0000));
      issue_command(mrtc_pkg::CMD_RESERVE, b, len, ea, rt);
    end else if (pick < 95) begin
      b[31:0] = pick_address();
      issue_command(mrtc_pkg::CMD_CHECK, b, len, ea, rt);
    end else begin
      issue_command(mrtc_pkg::CMD_NOP, b, len, ea, rt);
    end
  endtask

  task automatic test_empty_table();
    issue_command(mrtc_pkg::CMD_CHECK, 64'h0, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_RESERVE, 64'h0010_0000, 64'h0, 32'h0020_0000,
                  mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_NOP, '1, '1, '1, '1);
  endtask

  task automatic test_region_loads();
    issue_command(mrtc_pkg::CMD_LOAD, 64'h0, 64'h9_F000, 32'h0, mrtc_pkg::KIND_AVAIL);
    issue_command(mrtc_pkg::CMD_LOAD, 64'h0010_0000, 64'h3FF0_0000, 32'h0,
                  mrtc_pkg::KIND_AVAIL);
    issue_command(mrtc_pkg::CMD_LOAD, 64'h0020_0000, 64'h1_0000, 32'h0,
                  mrtc_pkg::KIND_RESV);
    issue_command(mrtc_pkg::CMD_LOAD, 64'h1_0000_0000, 64'h1000_0000, 32'h0,
                  mrtc_pkg::KIND_AVAIL);
    issue_command(mrtc_pkg::CMD_LOAD, 64'hFFFF_0000, 64'h2_0000, 32'h0,
                  mrtc_pkg::KIND_AVAIL);
    issue_command(mrtc_pkg::CMD_LOAD, 64'h0030_0000, 64'h1000, 32'h0,
                  mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_LOAD, 64'h0040_0000, 64'h1000, 32'h0, 8'hFF);
    issue_command(mrtc_pkg::CMD_LOAD, 64'h0050_0000, 64'h0, 32'h0, mrtc_pkg::KIND_AVAIL);
  endtask

  task automatic test_windows_and_reserves();
    issue_command(mrtc_pkg::CMD_CHECK, 64'h0010_0000, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_CHECK, 64'h000F_FFFF, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_CHECK, 64'h3FFF_EFFF, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_CHECK, 64'h3FFF_F000, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_CHECK, 64'h0020_0000, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_CHECK, 64'h0020_F000, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_CHECK, 64'hDEAD_BEEF_0050_0000, 64'h0, 32'h0,
                  mrtc_pkg::KIND_EMPTY);
    // lands in the slot that the empty-kind load left free
    issue_command(mrtc_pkg::CMD_RESERVE, 64'h0050_0000, 64'h0, 32'h0060_0000,
                  mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_CHECK, 64'h0050_0000, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
    issue_command(mrtc_pkg::CMD_RESERVE, 64'h0050_0800, 64'h0, 32'h0055_0000,
                  mrtc_pkg::KIND_EMPTY);
    // zero end: stored but never matches; slot is overwritten by the next load
    issue_command(mrtc_pkg::CMD_RESERVE, 64'h0070_0000, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
  endtask

  task automatic test_page_limits();
    write_page_limit('0);
    issue_command(mrtc_pkg::CMD_NOP, 64'h0, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
    write_page_limit(21'd300);
    issue_command(mrtc_pkg::CMD_CHECK, 64'h0010_0000, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
    write_page_limit(LIMIT_MAX);
    issue_command(mrtc_pkg::CMD_CHECK, 64'h0010_0000, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
  endtask

  task automatic test_random_traffic(int n_items, int spare_slots);
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        gap_max = 6 * $urandom_range(0, 1);
        stall_max = 6 * $urandom_range(0, 1);
      end
      random_command(spare_slots);
    end
    gap_max = 6;
    stall_max = 6;
  endtask

  task automatic test_backpressure();
    wait_idle();
    gap_max = 0;
    stall_max = 0;
    hold_cycles = 300;
    repeat (8) issue_command(mrtc_pkg::CMD_CHECK, {32'h0, pick_address()}, 64'h0, 32'h0,
                             mrtc_pkg::KIND_EMPTY);
    wait_idle();
    gap_max = 6;
    stall_max = 6;
  endtask

  task automatic test_page_sum_saturation();
    write_page_limit(LIMIT_MAX);
    repeat (3) issue_command(mrtc_pkg::CMD_LOAD, 64'h0010_0000, 64'hFFE0_0000, 32'h0,
                             mrtc_pkg::KIND_AVAIL);
    issue_command(mrtc_pkg::CMD_CHECK, 64'h0080_0000, 64'h0, 32'h0, mrtc_pkg::KIND_EMPTY);
  endtask

  // Receiver: long hold, per-result stall, otherwise ready
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    outcome_t exp_o;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      results_seen++;
      stall_left = $urandom_range(0, stall_max);
      if (pending_outcomes.size() == 0) begin
        error_count++;
        if (error_count <= 50)
          $display("%0t: unexpected transfer: expected none, actual status %0d", $time,
                   res_if.status);
      end else begin
        exp_o = pending_outcomes.pop_front();
        report_field("status", 32'(exp_o.status), 32'(res_if.status));
        report_field("available", 32'(exp_o.available), 32'(res_if.available));
        report_field("page_total", 32'(exp_o.page_total), 32'(res_if.page_total));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_outcomes.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cmd_if.valid = 1'b0;
    cmd_if.cmd = mrtc_pkg::CMD_NOP;
    cmd_if.base = '0;
    cmd_if.length = '0;
    cmd_if.end_addr = '0;
    cmd_if.region_type = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_start[i] = '0;
      tbl_end[i] = '0;
      tbl_high[i] = 1'b0;
      tbl_kind[i] = mrtc_pkg::KIND_EMPTY;
    end
    next_load = 0;
    pg_sum = '0;
    pg_limit = mrtc_pkg::LIMIT_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_region_loads();
    test_windows_and_reserves();
    test_page_limits();
    write_page_limit(21'($urandom_range(256, 32'd1048576)));
    test_random_traffic(900, 3);
    test_backpressure();
    test_page_sum_saturation();
    write_page_limit(21'($urandom_range(0, 32'd1048576)));
    test_random_traffic(900, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d loads, %0d reserves, %0d checks, %0d unused commands; %0d results",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], results_seen);
    $display("Outcomes: %0d done, %0d skipped, %0d table full, %0d refused, %0d usable hits",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], usable_seen);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
